>>> design/ncp_pkg.sv
// Shared types, codes and defaults for the nearest sketch curve pick block.
package ncp_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int ID_BITS_DEF    = 16;
    // Quotient bits of the segment parameter (unsigned Q0.32).
    localparam int DIV_STEPS      = 32;

    typedef enum logic [1:0] {
        K_POINT   = 2'd0,
        K_SEGMENT = 2'd1,
        K_CIRCLE  = 2'd2,
        K_ARC     = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_ACC_SET,
        OP_ACC_ADD,
        OP_SAVE_LEN2,
        OP_USE_END,
        OP_DIV,
        OP_OFF_X,
        OP_OFF_Y,
        OP_SQRT,
        OP_JUDGE
    } t_op;

    typedef enum logic [2:0] {
        MS_DXDX,
        MS_DYDY,
        MS_EXDX,
        MS_EYDY,
        MS_DXT,
        MS_DYT,
        MS_EXEX,
        MS_EYEY
    } t_msel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KIND,
        S_LEN_A,
        S_LEN_B,
        S_LEN_SAVE,
        S_DOT_A,
        S_DOT_B,
        S_DOT_CHK,
        S_OFF_X,
        S_OFF_Y,
        S_FIN_A,
        S_FIN_B,
        S_ROOT,
        S_WAIT,
        S_JUDGE,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op   op;
        t_msel sel;
        logic  emit;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic seg;
        logic last;
        logic acc_zero;
        logic dot_le0;
        logic dot_ge;
    } t_stat;

endpackage

>>> design/ncp_ctrl.sv
// Controller state machine that sequences the distance datapath for each word.
module ncp_ctrl
    import ncp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    t_op    r_post, n_post;

    // State and return registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_post  <= OP_NONE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_post  <= n_post;
        end
    end

    // Next state and commands. A multiply, divide or root is started in one
    // state and waited for in S_WAIT, which then issues the follow-up operation.
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_post     = r_post;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.sel  = MS_DXDX;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_KIND;
                end
            end
            S_KIND: begin
                n_state = i_stat.seg ? S_LEN_A : S_FIN_A;
            end
            S_LEN_A: begin
                o_cmd.op = OP_MUL; o_cmd.sel = MS_DXDX;
                n_post = OP_ACC_SET; n_ret = S_LEN_B; n_state = S_WAIT;
            end
            S_LEN_B: begin
                o_cmd.op = OP_MUL; o_cmd.sel = MS_DYDY;
                n_post = OP_ACC_ADD; n_ret = S_LEN_SAVE; n_state = S_WAIT;
            end
            S_LEN_SAVE: begin
                o_cmd.op = OP_SAVE_LEN2;
                n_state  = i_stat.acc_zero ? S_FIN_A : S_DOT_A;
            end
            S_DOT_A: begin
                o_cmd.op = OP_MUL; o_cmd.sel = MS_EXDX;
                n_post = OP_ACC_SET; n_ret = S_DOT_B; n_state = S_WAIT;
            end
            S_DOT_B: begin
                o_cmd.op = OP_MUL; o_cmd.sel = MS_EYDY;
                n_post = OP_ACC_ADD; n_ret = S_DOT_CHK; n_state = S_WAIT;
            end
            S_DOT_CHK: begin
                // Clamp to the start, clamp to the end, or divide for t.
                priority if (i_stat.dot_le0) begin
                    n_state = S_FIN_A;
                end else if (i_stat.dot_ge) begin
                    o_cmd.op = OP_USE_END;
                    n_state  = S_FIN_A;
                end else begin
                    o_cmd.op = OP_DIV;
                    n_post = OP_NONE; n_ret = S_OFF_X; n_state = S_WAIT;
                end
            end
            S_OFF_X: begin
                o_cmd.op = OP_MUL; o_cmd.sel = MS_DXT;
                n_post = OP_OFF_X; n_ret = S_OFF_Y; n_state = S_WAIT;
            end
            S_OFF_Y: begin
                o_cmd.op = OP_MUL; o_cmd.sel = MS_DYT;
                n_post = OP_OFF_Y; n_ret = S_FIN_A; n_state = S_WAIT;
            end
            S_FIN_A: begin
                o_cmd.op = OP_MUL; o_cmd.sel = MS_EXEX;
                n_post = OP_ACC_SET; n_ret = S_FIN_B; n_state = S_WAIT;
            end
            S_FIN_B: begin
                o_cmd.op = OP_MUL; o_cmd.sel = MS_EYEY;
                n_post = OP_ACC_ADD; n_ret = S_ROOT; n_state = S_WAIT;
            end
            S_ROOT: begin
                o_cmd.op = OP_SQRT;
                n_post = OP_NONE; n_ret = S_JUDGE; n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!i_stat.busy) begin
                    o_cmd.op = r_post;
                    n_state  = r_ret;
                end
            end
            S_JUDGE: begin
                o_cmd.op = OP_JUDGE;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                // A last word waits here until the output register is free.
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

>>> design/ncp_datapath.sv
// Datapath: vector registers, shift-add multiplier, divider, square root and best tracker.
module ncp_datapath
    import ncp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic                         i_first,
    input  logic                         i_last,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic        [COORD_BITS-2:0] i_tol,
    input  logic        [1:0]            i_kind,
    input  logic signed [COORD_BITS-1:0] i_a,
    input  logic signed [COORD_BITS-1:0] i_b,
    input  logic signed [COORD_BITS-1:0] i_c,
    input  logic signed [COORD_BITS-1:0] i_d,
    input  logic        [ID_BITS-1:0]    i_id,
    output t_stat                        o_stat,
    output logic                         o_have_best,
    output logic        [ID_BITS-1:0]    o_best_id
);

    localparam int W  = COORD_BITS;
    localparam int MW = W + 2;                  // vector component width
    localparam int OW = (MW > DIV_STEPS) ? MW : DIV_STEPS; // multiplier operand
    localparam int PW = 2 * OW;                 // product width
    localparam int AW = PW + 2;                 // signed accumulator width
    localparam int RW = AW / 2;                 // root width
    localparam int CW = $clog2(RW + 1);

    function automatic logic [OW-1:0] magof(input logic signed [MW-1:0] v);
        logic [MW-1:0] m;
        m = v[MW-1] ? MW'(-v) : MW'(v);
        return OW'(m);
    endfunction

    function automatic logic signed [MW-1:0] sx(input logic signed [W-1:0] v);
        return {{2{v[W-1]}}, v};
    endfunction

    logic [1:0]             r_kind;
    logic                   r_last;
    logic signed [W-1:0]    r_c;
    logic [ID_BITS-1:0]     r_id;
    logic signed [MW-1:0]   r_ex, r_ey, r_dx, r_dy, r_fx, r_fy;
    logic [PW-1:0]          r_len2;
    logic signed [AW-1:0]   r_acc;
    logic [DIV_STEPS-1:0]   r_t;
    logic [PW-1:0]          r_prod;
    logic [OW-1:0]          r_mcand;
    logic                   r_pneg;
    logic                   r_busy;
    t_op                    r_run;
    logic [CW-1:0]          r_cnt;
    logic [AW-1:0]          r_rem;
    logic [AW-1:0]          r_sn;
    logic [OW+3:0]          r_srem;
    logic [RW-1:0]          r_root;
    logic [W-1:0]           r_best;
    logic [ID_BITS-1:0]     r_best_id;
    logic                   r_have;

    // Operand selection for a multiply.
    logic signed [MW-1:0] sa, sb;
    logic                 use_t;
    always_comb begin
        sa = r_dx; sb = r_dx; use_t = 1'b0;
        unique case (i_cmd.sel)
            MS_DXDX: begin sa = r_dx; sb = r_dx; end
            MS_DYDY: begin sa = r_dy; sb = r_dy; end
            MS_EXDX: begin sa = r_ex; sb = r_dx; end
            MS_EYDY: begin sa = r_ey; sb = r_dy; end
            MS_DXT:  begin sa = r_dx; use_t = 1'b1; end
            MS_DYT:  begin sa = r_dy; use_t = 1'b1; end
            MS_EXEX: begin sa = r_ex; sb = r_ex; end
            MS_EYEY: begin sa = r_ey; sb = r_ey; end
            default: begin sa = r_dx; sb = r_dx; end
        endcase
    end

    // One multiplier step, the signed product, and the rounded segment offset.
    logic [OW:0]          mul_sum;
    logic signed [AW-1:0] prod_s;
    logic [PW:0]          off_sum;
    logic [MW-1:0]        off;
    always_comb begin
        mul_sum = {1'b0, r_prod[PW-1:OW]} + (r_prod[0] ? {1'b0, r_mcand} : '0);
        prod_s  = r_pneg ? -$signed(AW'(r_prod)) : $signed(AW'(r_prod));
        off_sum = {1'b0, r_prod} + ((PW+1)'(1) << (DIV_STEPS - 1));
        off     = off_sum[DIV_STEPS +: MW];
    end

    // Restoring division step and square root step.
    logic [AW-1:0]  div_sh;
    logic           div_ge;
    logic [OW+3:0]  sq_cur, sq_trial;
    logic           sq_ge;
    always_comb begin
        div_sh   = {r_rem[AW-2:0], 1'b0};
        div_ge   = div_sh >= {2'b00, r_len2};
        sq_cur   = {r_srem[OW+1:0], r_sn[AW-1:AW-2]};
        sq_trial = {1'b0, r_root, 2'b01};
        sq_ge    = sq_cur >= sq_trial;
    end

    // Final distance: to the root, or to the rim, saturated.
    logic signed [RW+1:0] rim_diff;
    logic [RW+1:0]        dsel;
    logic [W-1:0]         cur_dist;
    always_comb begin
        rim_diff = $signed({2'b00, r_root}) - $signed((RW+2)'(r_c));
        dsel     = (r_kind[1]) ? (rim_diff[RW+1] ? (RW+2)'(-rim_diff) : (RW+2)'(rim_diff))
                               : {2'b00, r_root};
        cur_dist = (|dsel[RW+1:W]) ? '1 : dsel[W-1:0];
    end

    // Control registers: unit busy flag, counter and the best so far.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_run     <= OP_NONE;
            r_cnt     <= '0;
            r_best    <= '0;
            r_best_id <= '0;
            r_have    <= 1'b0;
        end else begin
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) r_busy <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_MUL:  begin r_busy <= 1'b1; r_run <= OP_MUL;  r_cnt <= CW'(OW); end
                OP_DIV:  begin r_busy <= 1'b1; r_run <= OP_DIV;  r_cnt <= CW'(DIV_STEPS); end
                OP_SQRT: begin r_busy <= 1'b1; r_run <= OP_SQRT; r_cnt <= CW'(RW); end
                OP_LOAD: begin
                    if (i_first) begin
                        r_best    <= {1'b0, i_tol};
                        r_best_id <= '0;
                        r_have    <= 1'b0;
                    end
                end
                OP_JUDGE: begin
                    if (cur_dist <= r_best) begin
                        r_best    <= cur_dist;
                        r_best_id <= r_id;
                        r_have    <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            unique case (r_run)
                OP_MUL:  r_prod <= {mul_sum, r_prod[OW-1:1]};
                OP_DIV: begin
                    r_rem <= div_ge ? div_sh - {2'b00, r_len2} : div_sh;
                    r_t   <= {r_t[DIV_STEPS-2:0], div_ge};
                end
                OP_SQRT: begin
                    r_srem <= sq_ge ? sq_cur - sq_trial : sq_cur;
                    r_root <= {r_root[RW-2:0], sq_ge};
                    r_sn   <= {r_sn[AW-3:0], 2'b00};
                end
                default: ;
            endcase
        end
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_kind <= i_kind;
                r_last <= i_last;
                r_c    <= i_c;
                r_id   <= i_id;
                r_ex   <= sx(i_px) - sx(i_a);
                r_ey   <= sx(i_py) - sx(i_b);
                r_dx   <= sx(i_c) - sx(i_a);
                r_dy   <= sx(i_d) - sx(i_b);
                r_fx   <= sx(i_px) - sx(i_c);
                r_fy   <= sx(i_py) - sx(i_d);
            end
            OP_MUL: begin
                r_mcand <= magof(sa);
                r_prod  <= PW'(use_t ? OW'(r_t) : magof(sb));
                r_pneg  <= sa[MW-1] ^ (sb[MW-1] & ~use_t);
            end
            OP_ACC_SET:   r_acc  <= prod_s;
            OP_ACC_ADD:   r_acc  <= r_acc + prod_s;
            OP_SAVE_LEN2: r_len2 <= PW'(r_acc);
            OP_USE_END: begin
                r_ex <= r_fx;
                r_ey <= r_fy;
            end
            OP_DIV: begin
                r_rem <= AW'(r_acc);
                r_t   <= '0;
            end
            OP_OFF_X: r_ex <= r_pneg ? r_ex + $signed(off) : r_ex - $signed(off);
            OP_OFF_Y: r_ey <= r_pneg ? r_ey + $signed(off) : r_ey - $signed(off);
            OP_SQRT: begin
                r_sn   <= AW'(r_acc);
                r_srem <= '0;
                r_root <= '0;
            end
            default: ;
        endcase
    end

    // Status towards the controller.
    always_comb begin
        o_stat.busy     = r_busy;
        o_stat.seg      = (r_kind == K_SEGMENT);
        o_stat.last     = r_last;
        o_stat.acc_zero = (r_acc == '0);
        o_stat.dot_le0  = r_acc[AW-1] || (r_acc == '0);
        o_stat.dot_ge   = r_acc >= $signed({2'b00, r_len2});
    end

    assign o_have_best = r_have;
    assign o_best_id   = r_best_id;

endmodule

>>> design/nearest_sketch_curve_pick.sv
// Top level of the nearest sketch primitive pick: stream ports, output register, checks.
//
// Each input word carries the pointer, the pick tolerance and one primitive (point,
// segment, circle or arc); the block keeps the nearest primitive within tolerance,
// ties going to the later word, and after a word marked by tlast it offers one result
// word with the hit flag and id. Words are handled one at a time by a single
// shift-add multiplier (one bit per cycle), a restoring divider and a digit-by-digit
// square root. A point, circle or arc needs two products and the root, a segment
// clamped to an end six products and the root, and an interior segment eight
// products, the divide and the root. A pending result does not hold off the next
// input word; only a further last word waits for it.
module nearest_sketch_curve_pick
    import ncp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ID_BITS    = ID_BITS_DEF,
    localparam int IN_BITS   = 7 * COORD_BITS + 1 + ID_BITS,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((1 + ID_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // pointer_x, pointer_y, pick_tolerance, prim_kind, coord_a, coord_b, coord_c,
    // coord_d, prim_id, zero fill
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    input  logic             i_s_axis_tuser,   // first_item
    input  logic             i_s_axis_tlast,   // last_item
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // hit_found, hit_id, zero fill
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam int W = COORD_BITS;

    t_cmd               cmd;
    t_stat              stat;
    logic               have_best;
    logic [ID_BITS-1:0] best_id;
    logic               r_out_valid;
    logic               r_found;
    logic [ID_BITS-1:0] r_hit_id;

    ncp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_out_free (!r_out_valid || i_m_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ncp_datapath #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_first     (i_s_axis_tuser),
        .i_last      (i_s_axis_tlast),
        .i_px        (i_s_axis_tdata[0 +: W]),
        .i_py        (i_s_axis_tdata[W +: W]),
        .i_tol       (i_s_axis_tdata[2*W +: W-1]),
        .i_kind      (i_s_axis_tdata[3*W-1 +: 2]),
        .i_a         (i_s_axis_tdata[3*W+1 +: W]),
        .i_b         (i_s_axis_tdata[4*W+1 +: W]),
        .i_c         (i_s_axis_tdata[5*W+1 +: W]),
        .i_d         (i_s_axis_tdata[6*W+1 +: W]),
        .i_id        (i_s_axis_tdata[7*W+1 +: ID_BITS]),
        .o_stat      (stat),
        .o_have_best (have_best),
        .o_best_id   (best_id)
    );

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) begin
            r_found  <= have_best;
            r_hit_id <= have_best ? best_id : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_hit_id, r_found});

    // No input word is taken while an arithmetic unit is running.
    a_no_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.busy |-> !o_s_axis_tready)
        else $error("input accepted while datapath busy");

    // An issued result is shown in the next cycle.
    a_emit_shows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_m_axis_tvalid)
        else $error("result not presented after emit");

    // A miss reports id zero.
    a_miss_id_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !r_found) |-> (r_hit_id == '0))
        else $error("miss with non-zero id");

endmodule

>>> dv/nearest_sketch_curve_pick_tb.sv
// Self-checking testbench for the nearest sketch primitive pick block.
`timescale 1ns / 1ps

module nearest_sketch_curve_pick_tb;
    import ncp_pkg::*;

    localparam int  CYCLE_LIMIT = 3_000_000;
    localparam int  TAIL_CYCLES = 600;
    localparam int  HOLD_CYCLES = 3000;
    localparam longint unsigned DIST_SAT = 64'hFFFF_FFFF;

    typedef struct {
        logic               first;
        logic               last;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic        [30:0] tol;
        t_kind              kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic        [15:0] id;
    } t_prim;

    typedef struct {
        logic        found;
        logic [15:0] id;
    } t_pick;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [247:0] i_s_axis_tdata;   // pointer_x, pointer_y, pick_tolerance, prim_kind,
                                    // coord_a, coord_b, coord_c, coord_d, prim_id, zero fill
    logic         i_s_axis_tuser;   // first_item
    logic         i_s_axis_tlast;   // last_item
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [23:0]  o_m_axis_tdata;   // hit_found, hit_id, zero fill

    // Predictor state, mirrored from the block's running best
    longint unsigned nearest_dist;
    logic [15:0]     nearest_id;
    logic            nearest_valid;

    t_pick pick_queue[$];
    int    words_sent;
    int    picks_checked;
    int    mismatches;
    int    cycle_count;
    int    hold_left;
    logic  calm_sink;
    logic  calm_source;

    nearest_sketch_curve_pick i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Clock, 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Floor of the square root of a 128-bit value
    function automatic logic [63:0] floor_root(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            c = r | (64'd1 << k);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    function automatic longint unsigned span(longint x, longint y);
        logic [63:0] ux;
        logic [63:0] uy;
        ux = (x < 0) ? -x : x;
        uy = (y < 0) ? -y : y;
        return floor_root({64'd0, ux} * {64'd0, ux} + {64'd0, uy} * {64'd0, uy});
    endfunction

    // Distance from the pointer to a segment, parameter clamped to its ends
    function automatic longint unsigned segment_gap(longint px, longint py, longint ax,
                                                    longint ay, longint bx, longint by);
        longint              ex, ey, dx, dy, offx, offy;
        logic signed [127:0] sex, sey, sdx, sdy, dot;
        logic        [127:0] len2, quot, m;
        logic        [63:0]  udx, udy;
        logic        [31:0]  t;
        ex = px - ax;
        ey = py - ay;
        dx = bx - ax;
        dy = by - ay;
        sex = 128'(ex);
        sey = 128'(ey);
        sdx = 128'(dx);
        sdy = 128'(dy);
        udx = (dx < 0) ? -dx : dx;
        udy = (dy < 0) ? -dy : dy;
        len2 = {64'd0, udx} * {64'd0, udx} + {64'd0, udy} * {64'd0, udy};
        if (len2 == 0) return span(ex, ey);
        dot = sex * sdx + sey * sdy;
        if (dot <= 0) return span(ex, ey);
        if (dot >= $signed(len2)) return span(px - bx, py - by);
        quot = (dot << 32) / len2;
        t = quot[31:0];
        m = {64'd0, udx} * {96'd0, t} + (128'd1 << 31);
        offx = (dx < 0) ? -longint'(m[95:32]) : longint'(m[95:32]);
        m = {64'd0, udy} * {96'd0, t} + (128'd1 << 31);
        offy = (dy < 0) ? -longint'(m[95:32]) : longint'(m[95:32]);
        return span(ex - offx, ey - offy);
    endfunction

    // Advance the running best by one word; returns 1 when a pick is due
    function automatic bit pick_nearest(t_prim w, output t_pick res);
        longint unsigned gap;
        longint          diff;
        if (w.first) begin
            nearest_dist  = 64'(w.tol);
            nearest_id    = '0;
            nearest_valid = 1'b0;
        end
        case (w.kind)
            K_POINT:   gap = span(longint'(w.a) - w.px, longint'(w.b) - w.py);
            K_SEGMENT: gap = segment_gap(w.px, w.py, w.a, w.b, w.c, w.d);
            default: begin
                diff = longint'(span(longint'(w.px) - w.a, longint'(w.py) - w.b)) - w.c;
                gap  = (diff < 0) ? -diff : diff;
            end
        endcase
        if (gap > DIST_SAT) gap = DIST_SAT;
        if (gap <= nearest_dist) begin
            nearest_dist  = gap;
            nearest_id    = w.id;
            nearest_valid = 1'b1;
        end
        res.found = nearest_valid;
        res.id    = nearest_valid ? nearest_id : 16'd0;
        return w.last;
    endfunction

    // Offer one word, hold it until accepted, then predict
    task automatic send_word(t_prim w);
        t_pick res;
        if (!calm_source && $urandom_range(99) < 32) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= w.first;
        i_s_axis_tlast  <= w.last;
        i_s_axis_tdata  <= {7'd0, w.id, w.d, w.c, w.b, w.a, w.kind, w.tol, w.py, w.px};
        do @(posedge i_clk); while (!o_s_axis_tready);
        words_sent++;
        if (pick_nearest(w, res)) pick_queue = {pick_queue, res};
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
    endtask

    function automatic t_prim make_prim(int first, int last, int px, int py, int tol,
                                        t_kind kind, int a, int b, int c, int d, int id);
        t_prim w;
        w.first = first[0];
        w.last  = last[0];
        w.px    = px;
        w.py    = py;
        w.tol   = tol[30:0];
        w.kind  = kind;
        w.a     = a;
        w.b     = b;
        w.c     = c;
        w.d     = d;
        w.id    = id[15:0];
        return w;
    endfunction

    // A coordinate either anywhere or near a given centre
    function automatic logic [31:0] near_coord(logic [31:0] centre);
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return centre + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            2:       return centre + $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
            default: return centre + $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    function automatic t_prim random_prim(logic first, logic last, logic [31:0] px,
                                          logic [31:0] py, logic [30:0] tol);
        t_prim w;
        w.first = first;
        w.last  = last;
        w.px    = px;
        w.py    = py;
        w.tol   = tol;
        w.kind  = t_kind'($urandom_range(3));
        w.a     = near_coord(px);
        w.b     = near_coord(py);
        if (w.kind == K_SEGMENT) begin
            w.c = near_coord(px);
            w.d = near_coord(py);
        end else begin
            w.c = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
            w.d = $urandom;
        end
        w.id = 16'($urandom);
        return w;
    endfunction

    function automatic logic [30:0] random_tol();
        case ($urandom_range(3))
            0:       return 31'($urandom);
            1:       return 31'($urandom_range(0, 32'h0000_1000));
            default: return 31'($urandom_range(0, 32'h0080_0000));
        endcase
    endfunction

    // Checker: each result word against the oldest pending pick
    always @(posedge i_clk) begin
        t_pick exp_pick;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pick_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word: found=%0b id=%0h",
                             o_m_axis_tdata[0], o_m_axis_tdata[16:1]);
            end else begin
                exp_pick = pick_queue.pop_front();
                picks_checked++;
                if (o_m_axis_tdata[0] !== exp_pick.found ||
                    o_m_axis_tdata[16:1] !== exp_pick.id ||
                    o_m_axis_tdata[23:17] !== 7'd0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Pick %0d: expected found=%0b id=%0h, got found=%0b id=%0h",
                                 picks_checked, exp_pick.found, exp_pick.id,
                                 o_m_axis_tdata[0], o_m_axis_tdata[16:1]);
                end
            end
        end
    end

    // Result side ready, with random stalls and a counted hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= calm_sink || ($urandom_range(99) >= 32);
        end
    end

    // Run-length guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nearest_sketch_curve_pick verification failed");
            $finish;
        end
    end

    // With no first word since reset only exact hits count
    task automatic test_no_first_after_reset();
        send_word(make_prim(0, 1, 32'h0001_0000, 32'h0002_0000, 0, K_POINT,
                            32'h0001_0000, 32'h0002_0000, 0, 0, 16'h0011));
        send_word(make_prim(0, 1, 32'h0001_0000, 32'h0002_0000, 31'h7FFF_FFFF, K_POINT,
                            32'h0001_0001, 32'h0002_0000, 0, 0, 16'h0022));
    endtask

    // Field extremes, every kind and the corner cases
    task automatic test_directed();
        // Saturating distance against the largest tolerance
        send_word(make_prim(1, 0, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, K_POINT,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            16'hFFFF));
        send_word(make_prim(0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 31'h0, K_SEGMENT,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            16'h0000));
        // Segment: zero length, clamp at start, clamp at end, interior
        send_word(make_prim(1, 0, 0, 0, 32'h0003_0000, K_SEGMENT,
                            32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 1));
        send_word(make_prim(0, 0, 0, 0, 32'h0005_0000, K_SEGMENT,
                            32'h0001_0000, 0, 32'h0005_0000, 0, 2));
        send_word(make_prim(0, 0, 32'h0009_0000, 0, 32'h0005_0000, K_SEGMENT,
                            32'h0001_0000, 0, 32'h0005_0000, 0, 3));
        send_word(make_prim(0, 1, 32'h0001_5555, 32'h0000_3333, 32'h0005_0000, K_SEGMENT,
                            32'hFFFF_0000, 32'hFFFD_0000, 32'h0003_0000, 32'h0004_1234, 4));
        // Circle, arc and a negative radius; the tie goes to the later word
        send_word(make_prim(1, 0, 32'h0010_0000, 32'h0010_0000, 32'h0002_0000, K_CIRCLE,
                            0, 0, 32'h0016_0000, 32'hDEAD_BEEF, 5));
        send_word(make_prim(0, 0, 32'h0010_0000, 32'h0010_0000, 32'h0002_0000, K_ARC,
                            0, 0, 32'h0016_0000, 32'h1234_5678, 6));
        send_word(make_prim(0, 1, 32'h0010_0000, 32'h0010_0000, 32'h0002_0000, K_CIRCLE,
                            32'h0010_0000, 32'h0010_0000, 32'hFFFF_8000, 0, 7));
        // No hit within tolerance
        send_word(make_prim(1, 1, 0, 0, 32'h0000_0100, K_POINT,
                            32'h0100_0000, 0, 32'h5555_5555, 32'hAAAA_AAAA, 8));
        // Tolerance changing mid-query, then words after a last without a new first
        send_word(make_prim(1, 0, 0, 0, 32'h0000_1000, K_POINT, 32'h0000_0800, 0, 0, 0, 9));
        send_word(make_prim(0, 1, 0, 0, 31'h7FFF_FFFF, K_POINT, 32'h0010_0000, 0, 0, 0, 10));
        send_word(make_prim(0, 1, 0, 0, 31'h7FFF_FFFF, K_POINT, 32'h0000_0400, 0, 0, 0, 11));
        send_word(make_prim(0, 1, 32'hAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA, K_ARC,
                            32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'h7FFF_FFFF,
                            16'hAAAA));
    endtask

    // Mostly well-formed queries with random content, some stray flags
    task automatic test_random_queries(int n_words);
        logic [31:0] px, py;
        logic [30:0] tol;
        int          len;
        int          sent;
        sent = 0;
        while (sent < n_words) begin
            px  = $urandom;
            py  = $urandom;
            tol = random_tol();
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(9) == 0)
                    send_word(random_prim(1'($urandom), 1'($urandom), $urandom, $urandom,
                                          31'($urandom)));
                else
                    send_word(random_prim(k == 0, k == len - 1, px, py, tol));
                sent++;
            end
        end
    endtask

    // Hold results back while many one-word queries queue up behind them
    task automatic test_result_backpressure();
        hold_left <= HOLD_CYCLES;
        calm_source = 1'b1;
        for (int k = 0; k < 12; k++)
            send_word(random_prim(1'b1, 1'b1, $urandom, $urandom, random_tol()));
        calm_source = 1'b0;
    endtask

    // Stretch with no idling on either side
    task automatic test_full_rate(int n_words);
        calm_source = 1'b1;
        calm_sink   = 1'b1;
        test_random_queries(n_words);
        calm_source = 1'b0;
        calm_sink   = 1'b0;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tuser  <= 1'b0;
        i_s_axis_tlast  <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        hold_left       = 0;
        calm_sink       = 1'b0;
        calm_source     = 1'b0;
        cycle_count     = 0;
        words_sent      = 0;
        picks_checked   = 0;
        mismatches      = 0;
        nearest_dist    = 0;
        nearest_id      = '0;
        nearest_valid   = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_no_first_after_reset();
        test_directed();
        test_random_queries(250);
        test_result_backpressure();
        test_full_rate(100);
        test_random_queries(170);
        stop_sending();

        while (pick_queue.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d primitive words and checked %0d pick results, %0d mismatching.",
                 words_sent, picks_checked, mismatches);
        $display("Covered all kinds, clamped segments, saturation, ties and result stalls.");
        if (mismatches == 0 && pick_queue.size() == 0) begin
            $display("nearest_sketch_curve_pick verification clean");
        end else begin
            $display("nearest_sketch_curve_pick verification failed");
        end
        $finish;
    end

endmodule
